// File: rtl/obeb_pkg.sv
`timescale 1ns / 1ps

package obeb_pkg;

  localparam int TICK_W   = 16;
  localparam int CPU_W    = 10;
  localparam int REC_W    = 4;
  localparam int PCT_W    = 15;
  localparam int SOLAR_W  = 14;
  localparam int LOAD_W   = 14;
  localparam int CHARGE_W = 23;
  localparam int ORBIT_W  = 17;

  localparam logic [ORBIT_W-1:0]  ORBIT_MS       = 17'd90000;
  localparam logic [15:0]         SUNLIT_MS      = 16'd55800;
  localparam logic [SOLAR_W-1:0]  SOLAR_PEAK_Q12 = 14'd11878;
  localparam logic [CHARGE_W-1:0] CAPACITY_Q10   = 23'd4096000;
  localparam logic [CHARGE_W-1:0] CHARGE_RESET   = 23'd3276800;
  localparam logic [CPU_W-1:0]    CPU_MAX        = 10'd1000;
  localparam logic [LOAD_W-1:0]   LOAD_BASE      = 14'd256;
  localparam logic [63:0]         PI_Q30         = 64'd3373259426;

  typedef struct packed {
    logic [TICK_W-1:0] tick_ms;
    logic [CPU_W-1:0]  cpu_load_tenths;
    logic [REC_W-1:0]  recovery_count;
  } item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCALE,
    ST_RECIP,
    ST_FIX,
    ST_ROM,
    ST_NET,
    ST_DIV,
    ST_CHARGE,
    ST_PCT,
    ST_OUT
  } state_t;

  // half sine in Q2.12 from an angle in Q30, truncated Taylor series
  function automatic logic [SOLAR_W-1:0] half_sine_q12(input logic [63:0] x);
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] v;
    term = x;
    sum  = x;
    term = (((term * x) >> 30) * x) >> 30;
    term = term / 64'd6;
    sum  = (sum >= term) ? sum - term : 64'd0;
    term = (((term * x) >> 30) * x) >> 30;
    term = term / 64'd20;
    sum  = sum + term;
    term = (((term * x) >> 30) * x) >> 30;
    term = term / 64'd42;
    sum  = (sum >= term) ? sum - term : 64'd0;
    term = (((term * x) >> 30) * x) >> 30;
    term = term / 64'd72;
    sum  = sum + term;
    term = (((term * x) >> 30) * x) >> 30;
    term = term / 64'd110;
    sum  = (sum >= term) ? sum - term : 64'd0;
    term = (((term * x) >> 30) * x) >> 30;
    term = term / 64'd156;
    sum  = sum + term;
    term = (((term * x) >> 30) * x) >> 30;
    term = term / 64'd210;
    sum  = (sum >= term) ? sum - term : 64'd0;
    v = (sum * 64'(SOLAR_PEAK_Q12) + (64'd1 << 29)) >> 30;
    if (v > 64'(SOLAR_PEAK_Q12)) begin
      v = 64'(SOLAR_PEAK_Q12);
    end
    return v[SOLAR_W-1:0];
  endfunction

endpackage

// File: rtl/obeb_front.sv
`timescale 1ns / 1ps

module obeb_front #(
  parameter int MAX_RECOVERIES = 15
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [obeb_pkg::TICK_W-1:0]   in_tick_ms,
  input  logic [obeb_pkg::CPU_W-1:0]    in_cpu_load_tenths,
  input  logic [obeb_pkg::REC_W-1:0]    in_recovery_count,
  output logic                          push_valid,
  input  logic                          push_ready,
  output obeb_pkg::item_t               push_item
);

  logic            hold_valid_r;
  logic            hold_valid_nxt;
  obeb_pkg::item_t hold_item_r;
  obeb_pkg::item_t hold_item_nxt;

  assign in_ready   = !hold_valid_r || push_ready;
  assign push_valid = hold_valid_r;
  assign push_item  = hold_item_r;

  // clamp load and recovery count on the way in
  always_comb begin
    hold_item_nxt.tick_ms = in_tick_ms;
    if (in_cpu_load_tenths > obeb_pkg::CPU_MAX) begin
      hold_item_nxt.cpu_load_tenths = obeb_pkg::CPU_MAX;
    end else begin
      hold_item_nxt.cpu_load_tenths = in_cpu_load_tenths;
    end
    if (32'(in_recovery_count) > MAX_RECOVERIES) begin
      hold_item_nxt.recovery_count = obeb_pkg::REC_W'(MAX_RECOVERIES);
    end else begin
      hold_item_nxt.recovery_count = in_recovery_count;
    end
  end

  always_comb begin
    hold_valid_nxt = hold_valid_r;
    if (in_valid && in_ready) begin
      hold_valid_nxt = 1'b1;
    end else if (push_ready) begin
      hold_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_valid_r <= 1'b0;
    end else begin
      hold_valid_r <= hold_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      hold_item_r <= hold_item_nxt;
    end
  end

endmodule

// File: rtl/obeb_queue.sv
`timescale 1ns / 1ps

module obeb_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push_valid,
  output logic            push_ready,
  input  obeb_pkg::item_t push_item,
  output logic            pop_valid,
  input  logic            pop_ready,
  output obeb_pkg::item_t pop_item
);

  obeb_pkg::item_t slot_r [2];
  logic            wr_ptr_r;
  logic            wr_ptr_nxt;
  logic            rd_ptr_r;
  logic            rd_ptr_nxt;
  logic [1:0]      count_r;
  logic [1:0]      count_nxt;
  logic            do_push;
  logic            do_pop;

  assign push_ready = (count_r != 2'd2);
  assign pop_valid  = (count_r != 2'd0);
  assign pop_item   = slot_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = do_push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? !rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + 2'(do_push) - 2'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

// File: rtl/obeb_back.sv
`timescale 1ns / 1ps

module obeb_back #(
  parameter int SINE_TABLE_ENTRIES = 256
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic                            cfg_wdata,
  input  logic                            pop_valid,
  output logic                            pop_ready,
  input  obeb_pkg::item_t                 pop_item,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [obeb_pkg::PCT_W-1:0]      out_battery_percent,
  output logic [obeb_pkg::SOLAR_W-1:0]    out_solar_current,
  output logic                            out_in_sunlight,
  output logic [obeb_pkg::LOAD_W-1:0]     out_load_watts
);

  localparam int NW  = $clog2(SINE_TABLE_ENTRIES + 1);
  localparam int IW  = $clog2(SINE_TABLE_ENTRIES);
  localparam int PW  = obeb_pkg::ORBIT_W + NW;
  localparam int SI  = 16 + NW;
  localparam logic [63:0] RI = (64'd1 << SI) / 64'd55800;
  localparam int RIW = $clog2(RI + 64'd1);
  localparam int QW  = NW + 1;

  // reciprocals for the fixed divisors
  localparam logic [9:0]  RL = 10'd524;
  localparam logic [23:0] RD = 24'd8589934;
  localparam logic [15:0] RP = 16'd52428;

  localparam logic [QW-1:0] IDX_LAST = QW'(SINE_TABLE_ENTRIES - 1);
  localparam logic [QW-1:0] IDX_N    = QW'(SINE_TABLE_ENTRIES);

  logic [obeb_pkg::SOLAR_W-1:0] sine_rom [SINE_TABLE_ENTRIES];

  for (genvar gi = 0; gi < SINE_TABLE_ENTRIES; gi++) begin : g_sine
    localparam logic [63:0] J =
      (2 * gi <= SINE_TABLE_ENTRIES) ? 64'(gi) : 64'(SINE_TABLE_ENTRIES - gi);
    localparam logic [63:0] X = (obeb_pkg::PI_Q30 * J) / SINE_TABLE_ENTRIES;
    localparam logic [obeb_pkg::SOLAR_W-1:0] V = obeb_pkg::half_sine_q12(X);
    assign sine_rom[gi] = V;
  end

  obeb_pkg::state_t state_r;
  obeb_pkg::state_t state_nxt;

  logic                            pop;
  logic                            out_load;

  logic                            force_drain_r;
  logic [obeb_pkg::ORBIT_W-1:0]    orbit_r;
  logic [obeb_pkg::ORBIT_W-1:0]    orbit_nxt;
  logic [obeb_pkg::CHARGE_W-1:0]   charge_r;
  logic [obeb_pkg::CHARGE_W-1:0]   charge_nxt;
  logic                            out_valid_r;

  logic [obeb_pkg::TICK_W-1:0]     tick_r;
  logic [obeb_pkg::CPU_W-1:0]      cpu_r;
  logic [obeb_pkg::REC_W-1:0]      rec_r;
  logic [PW-1:0]                   p_r;
  logic [18:0]                     lv_r;
  logic                            sunlit_r;
  logic [QW-1:0]                   iq0_r;
  logic [9:0]                      lq0_r;
  logic [IW-1:0]                   idx_r;
  logic [obeb_pkg::LOAD_W-1:0]     load_r;
  logic [obeb_pkg::SOLAR_W-1:0]    rom_q_r;
  logic [obeb_pkg::SOLAR_W-1:0]    solar_r;
  logic signed [36:0]              num_r;
  logic [29:0]                     m32_r;
  logic                            neg_r;
  logic [23:0]                     dq0_r;
  logic [17:0]                     pv_r;
  logic [15:0]                     pq0_r;

  logic [obeb_pkg::PCT_W-1:0]      pct_out_r;
  logic [obeb_pkg::SOLAR_W-1:0]    solar_out_r;
  logic                            sunlit_out_r;
  logic [obeb_pkg::LOAD_W-1:0]     load_out_r;

  logic [obeb_pkg::ORBIT_W:0]      orbit_sum;
  logic [PW+RIW-1:0]               iprod;
  logic [28:0]                     lprod;
  logic [PW-1:0]                   imul;
  logic [PW-1:0]                   irem;
  logic [QW-1:0]                   iq;
  logic [QW-1:0]                   iq_clamp;
  logic [18:0]                     lrem;
  logic [9:0]                      lq;
  logic [obeb_pkg::SOLAR_W-1:0]    solar_sel;
  logic signed [19:0]              diff;
  logic signed [36:0]              num;
  logic [35:0]                     mag;
  logic [53:0]                     dprod;
  logic [29:0]                     drem;
  logic [23:0]                     dq;
  logic signed [25:0]              ch;
  logic [obeb_pkg::CHARGE_W-1:0]   pv_sum;
  logic [33:0]                     pprod;
  logic [17:0]                     prem;
  logic [15:0]                     pq;

  // phase wrap
  always_comb begin
    orbit_sum = (obeb_pkg::ORBIT_W + 1)'(orbit_r) + (obeb_pkg::ORBIT_W + 1)'(pop_item.tick_ms);
    if (orbit_sum >= (obeb_pkg::ORBIT_W + 1)'(obeb_pkg::ORBIT_MS)) begin
      orbit_nxt = obeb_pkg::ORBIT_W'(orbit_sum - (obeb_pkg::ORBIT_W + 1)'(obeb_pkg::ORBIT_MS));
    end else begin
      orbit_nxt = obeb_pkg::ORBIT_W'(orbit_sum);
    end
  end

  // reciprocal products and their corrections
  always_comb begin
    iprod = (PW + RIW)'(p_r) * (PW + RIW)'(RI[RIW-1:0]);
    lprod = 29'(lv_r) * 29'(RL);
    imul  = PW'(iq0_r) * PW'(obeb_pkg::SUNLIT_MS);
    irem  = p_r - imul;
    iq    = (irem >= PW'(obeb_pkg::SUNLIT_MS)) ? iq0_r + QW'(1) : iq0_r;
    iq_clamp = (iq >= IDX_N) ? IDX_LAST : iq;
    lrem  = lv_r - 19'(lq0_r) * 19'd1000;
    lq    = (lrem >= 19'd1000) ? lq0_r + 10'd1 : lq0_r;
  end

  // net power over the tick and its rounding to charge units
  always_comb begin
    solar_sel = sunlit_r ? rom_q_r : '0;
    diff = $signed(20'({solar_sel, 2'b00}) + 20'(solar_sel))
         - $signed(20'({load_r, 4'b0000}));
    if (force_drain_r) begin
      num = -$signed(37'({tick_r, 15'b0}));
    end else begin
      num = 37'(diff) * $signed({21'b0, tick_r});
    end
    mag   = num_r[36] ? 36'(-num_r) + 36'd2000 : 36'(num_r) + 36'd2000;
    dprod = 54'(mag[34:5]) * 54'(RD);
    drem  = m32_r - 30'(dq0_r) * 30'd125;
    dq    = (drem >= 30'd125) ? dq0_r + 24'd1 : dq0_r;
    if (neg_r) begin
      ch = $signed(26'(charge_r)) - $signed(26'(dq));
    end else begin
      ch = $signed(26'(charge_r)) + $signed(26'(dq));
    end
    if (ch > $signed(26'(obeb_pkg::CAPACITY_Q10))) begin
      charge_nxt = obeb_pkg::CAPACITY_Q10;
    end else if (ch < 26'sd0) begin
      charge_nxt = '0;
    end else begin
      charge_nxt = obeb_pkg::CHARGE_W'(ch);
    end
  end

  // charge to percent
  always_comb begin
    pv_sum = charge_r + obeb_pkg::CHARGE_W'(80);
    pprod  = 34'(pv_sum[22:5]) * 34'(RP);
    prem   = pv_r - 18'(pq0_r) * 18'd5;
    pq     = (prem >= 18'd5) ? pq0_r + 16'd1 : pq0_r;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      obeb_pkg::ST_IDLE:   if (pop_valid) state_nxt = obeb_pkg::ST_SCALE;
      obeb_pkg::ST_SCALE:  state_nxt = obeb_pkg::ST_RECIP;
      obeb_pkg::ST_RECIP:  state_nxt = obeb_pkg::ST_FIX;
      obeb_pkg::ST_FIX:    state_nxt = obeb_pkg::ST_ROM;
      obeb_pkg::ST_ROM:    state_nxt = obeb_pkg::ST_NET;
      obeb_pkg::ST_NET:    state_nxt = obeb_pkg::ST_DIV;
      obeb_pkg::ST_DIV:    state_nxt = obeb_pkg::ST_CHARGE;
      obeb_pkg::ST_CHARGE: state_nxt = obeb_pkg::ST_PCT;
      obeb_pkg::ST_PCT:    state_nxt = obeb_pkg::ST_OUT;
      obeb_pkg::ST_OUT:    if (!out_valid_r || out_ready) state_nxt = obeb_pkg::ST_IDLE;
      default:             state_nxt = obeb_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    pop      = 1'b0;
    out_load = 1'b0;
    case (state_r)
      obeb_pkg::ST_IDLE: pop      = pop_valid;
      obeb_pkg::ST_OUT:  out_load = !out_valid_r || out_ready;
      default: begin
        pop      = 1'b0;
        out_load = 1'b0;
      end
    endcase
  end

  assign pop_ready = pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= obeb_pkg::ST_IDLE;
      force_drain_r <= 1'b0;
      orbit_r       <= '0;
      charge_r      <= obeb_pkg::CHARGE_RESET;
      out_valid_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        force_drain_r <= cfg_wdata;
      end
      if (pop) begin
        orbit_r <= orbit_nxt;
      end
      if (state_r == obeb_pkg::ST_CHARGE) begin
        charge_r <= charge_nxt;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    rom_q_r <= sine_rom[idx_r];
    case (state_r)
      obeb_pkg::ST_IDLE: begin
        tick_r <= pop_item.tick_ms;
        cpu_r  <= pop_item.cpu_load_tenths;
        rec_r  <= pop_item.recovery_count;
      end
      obeb_pkg::ST_SCALE: begin
        p_r      <= PW'(orbit_r) * PW'(SINE_TABLE_ENTRIES);
        lv_r     <= {cpu_r, 9'b0} + 19'd500;
        sunlit_r <= (16'(orbit_r) < obeb_pkg::SUNLIT_MS) && !orbit_r[16];
      end
      obeb_pkg::ST_RECIP: begin
        iq0_r <= iprod[SI +: QW];
        lq0_r <= lprod[28:19];
      end
      obeb_pkg::ST_FIX: begin
        idx_r  <= IW'(iq_clamp);
        load_r <= obeb_pkg::LOAD_BASE + obeb_pkg::LOAD_W'(lq)
                + obeb_pkg::LOAD_W'(rec_r) * obeb_pkg::LOAD_W'(640);
      end
      obeb_pkg::ST_NET: begin
        solar_r <= solar_sel;
        num_r   <= num;
      end
      obeb_pkg::ST_DIV: begin
        neg_r <= num_r[36];
        m32_r <= mag[34:5];
        dq0_r <= dprod[53:30];
      end
      obeb_pkg::ST_PCT: begin
        pv_r  <= pv_sum[22:5];
        pq0_r <= pprod[33:18];
      end
      obeb_pkg::ST_OUT: begin
        if (out_load) begin
          pct_out_r    <= obeb_pkg::PCT_W'(pq);
          solar_out_r  <= solar_r;
          sunlit_out_r <= sunlit_r;
          load_out_r   <= load_r;
        end
      end
      default: begin
        tick_r <= tick_r;
      end
    endcase
  end

  assign out_valid           = out_valid_r;
  assign out_battery_percent = pct_out_r;
  assign out_solar_current   = solar_out_r;
  assign out_in_sunlight     = sunlit_out_r;
  assign out_load_watts      = load_out_r;

endmodule

// File: rtl/orbital_battery_energy_balance.sv
`timescale 1ns / 1ps

// Orbital battery energy balance. Each input word is one simulation tick;
// the block advances the orbit phase, looks up the solar current, forms the
// load and integrates the net power into the battery charge, then returns
// one result word. A front register and a two-word queue take new words
// while the back end works. The back end is a sequencer that steps each
// word through idle, scale, reciprocal, fix, lookup, net power, divide,
// charge, percent and output, taking a new word only back in idle. A
// finished result waits in the output register, and the next word waits
// in output until it is taken. force_drain is to be written through
// cfg_we/cfg_wdata only while the block is idle; it is not enforced.
module orbital_battery_energy_balance #(
  parameter int SINE_TABLE_ENTRIES = 256,
  parameter int MAX_RECOVERIES     = 15
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic                          cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [obeb_pkg::TICK_W-1:0]   in_tick_ms,
  input  logic [obeb_pkg::CPU_W-1:0]    in_cpu_load_tenths,
  input  logic [obeb_pkg::REC_W-1:0]    in_recovery_count,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [obeb_pkg::PCT_W-1:0]    out_battery_percent,
  output logic [obeb_pkg::SOLAR_W-1:0]  out_solar_current,
  output logic                          out_in_sunlight,
  output logic [obeb_pkg::LOAD_W-1:0]   out_load_watts
);

  logic            push_valid;
  logic            push_ready;
  obeb_pkg::item_t push_item;
  logic            pop_valid;
  logic            pop_ready;
  obeb_pkg::item_t pop_item;

  obeb_front #(
    .MAX_RECOVERIES(MAX_RECOVERIES)
  ) u_front (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_tick_ms         (in_tick_ms),
    .in_cpu_load_tenths (in_cpu_load_tenths),
    .in_recovery_count  (in_recovery_count),
    .push_valid         (push_valid),
    .push_ready         (push_ready),
    .push_item          (push_item)
  );

  obeb_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_item   (pop_item)
  );

  obeb_back #(
    .SINE_TABLE_ENTRIES(SINE_TABLE_ENTRIES)
  ) u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_wdata           (cfg_wdata),
    .pop_valid           (pop_valid),
    .pop_ready           (pop_ready),
    .pop_item            (pop_item),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_battery_percent (out_battery_percent),
    .out_solar_current   (out_solar_current),
    .out_in_sunlight     (out_in_sunlight),
    .out_load_watts      (out_load_watts)
  );

endmodule
